### rtl/wfd_pkg.sv
// Package for the WebSocket frame decoder: result kinds, stream widths and
// the result record passed from the parser to the output register.
// No dependencies.
package wfd_pkg;

  localparam int ByteW = 8;
  localparam int LenW = 64;
  localparam int OpcodeW = 4;
  localparam int KeyW = 32;
  localparam int CountW = 4;
  localparam int OutDataW = 80;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [CountW-1:0] Ext16Bytes = 4'd2;
  localparam logic [CountW-1:0] Ext64Bytes = 4'd8;
  localparam logic [CountW-1:0] KeyBytes = 4'd4;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic               kind;
    logic               frame_final;
    logic [OpcodeW-1:0] frame_opcode;
    logic               was_masked;
    logic [LenW-1:0]    frame_length;
    logic [ByteW-1:0]   payload_byte;
    logic               last_of_frame;
  } wfd_result_t;

endpackage

### rtl/wfd_parser.sv
// Frame parser of the WebSocket decoder: holds the header state and turns one
// stream byte per step into at most one result. Depends on wfd_pkg.
module wfd_parser
  import wfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [ByteW-1:0] data_byte,
  output logic             res_valid,
  output wfd_result_t      res
);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t             parse_phase, parse_phase_next;
  logic [CountW-1:0]  header_byte_count, header_byte_count_next;
  logic [LenW-1:0]    length_value, length_value_next;
  logic [LenW-1:0]    bytes_remaining, bytes_remaining_next;
  logic [KeyW-1:0]    key_word, key_word_next;
  logic [1:0]         key_position, key_position_next;
  logic               held_final, held_final_next;
  logic [OpcodeW-1:0] held_opcode, held_opcode_next;
  logic               held_masked, held_masked_next;

  logic [6:0]         len7;
  logic [CountW-1:0]  count_dec;
  logic [ByteW-1:0]   key_byte;
  logic               finish;
  logic               pay_last;
  logic [ByteW-1:0]   pay_value;

  assign len7 = data_byte[6:0];
  assign count_dec = header_byte_count - CountW'(1);
  assign pay_last = (bytes_remaining == LenW'(1));

  always_comb begin
    case (key_position)
      2'd0:    key_byte = key_word[31:24];
      2'd1:    key_byte = key_word[23:16];
      2'd2:    key_byte = key_word[15:8];
      default: key_byte = key_word[7:0];
    endcase
    pay_value = held_masked ? (data_byte ^ key_byte) : data_byte;
  end

  always_comb begin
    parse_phase_next = parse_phase;
    header_byte_count_next = header_byte_count;
    length_value_next = length_value;
    bytes_remaining_next = bytes_remaining;
    key_word_next = key_word;
    key_position_next = key_position;
    held_final_next = held_final;
    held_opcode_next = held_opcode;
    held_masked_next = held_masked;
    finish = 1'b0;
    res_valid = 1'b0;
    res.kind = KIND_HEADER;
    res.payload_byte = '0;
    res.last_of_frame = 1'b0;

    unique case (parse_phase)
      PH_SECOND: begin
        held_masked_next = data_byte[7];
        if (len7 == Len16Code) begin
          length_value_next = '0;
          header_byte_count_next = Ext16Bytes;
          parse_phase_next = PH_EXTLEN;
        end else if (len7 == Len64Code) begin
          length_value_next = '0;
          header_byte_count_next = Ext64Bytes;
          parse_phase_next = PH_EXTLEN;
        end else begin
          length_value_next = LenW'(len7);
          if (data_byte[7]) begin
            header_byte_count_next = KeyBytes;
            key_word_next = '0;
            parse_phase_next = PH_KEY;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        length_value_next = {length_value[LenW-ByteW-1:0], data_byte};
        header_byte_count_next = count_dec;
        if (count_dec == '0) begin
          if (held_masked) begin
            header_byte_count_next = KeyBytes;
            key_word_next = '0;
            parse_phase_next = PH_KEY;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_word_next = {key_word[KeyW-ByteW-1:0], data_byte};
        header_byte_count_next = count_dec;
        if (count_dec == '0) begin
          finish = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        key_position_next = key_position + 2'd1;
        bytes_remaining_next = bytes_remaining - LenW'(1);
        if (pay_last) begin
          parse_phase_next = PH_FIRST;
        end
        res_valid = 1'b1;
        res.kind = KIND_PAYLOAD;
        res.payload_byte = pay_value;
        res.last_of_frame = pay_last;
      end
      default: begin
        held_final_next = data_byte[7];
        held_opcode_next = data_byte[OpcodeW-1:0];
        held_masked_next = 1'b0;
        length_value_next = '0;
        bytes_remaining_next = '0;
        key_word_next = '0;
        key_position_next = '0;
        header_byte_count_next = '0;
        parse_phase_next = PH_SECOND;
      end
    endcase

    if (finish) begin
      bytes_remaining_next = length_value_next;
      key_position_next = '0;
      header_byte_count_next = '0;
      parse_phase_next = (length_value_next == '0) ? PH_FIRST : PH_PAYLOAD;
      res_valid = 1'b1;
      res.last_of_frame = (length_value_next == '0);
    end

    res.frame_final = held_final_next;
    res.frame_opcode = held_opcode_next;
    res.was_masked = held_masked_next;
    res.frame_length = length_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_FIRST;
      header_byte_count <= '0;
      length_value <= '0;
      bytes_remaining <= '0;
      key_word <= '0;
      key_position <= '0;
      held_final <= 1'b0;
      held_opcode <= '0;
      held_masked <= 1'b0;
    end else if (step) begin
      parse_phase <= parse_phase_next;
      header_byte_count <= header_byte_count_next;
      length_value <= length_value_next;
      bytes_remaining <= bytes_remaining_next;
      key_word <= key_word_next;
      key_position <= key_position_next;
      held_final <= held_final_next;
      held_opcode <= held_opcode_next;
      held_masked <= held_masked_next;
    end
  end

endmodule

### rtl/websocket_frame_decoder_unit.sv
// Top level of the WebSocket frame decoder: input register, parser and
// output register on stream ports. Depends on wfd_pkg and wfd_parser.
//
// The decoder takes one byte of a WebSocket stream per request and gives a
// header report once a frame header is complete, then one result per payload
// byte, unmasked with the frame's key when the mask bit is set. It accepts a
// byte in every cycle unless a byte waits in the input register while the output
// register holds a result that m_tready does not take; a byte passes from the
// input register through the parser, and any result that it yields is held in
// the output register. Reserved bits and control opcodes get no special handling.
module websocket_frame_decoder_unit
  import wfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ByteW-1:0]    s_tdata,   // data_byte[7:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // frame_final, frame_opcode[3:0],
                                         // was_masked, frame_length[63:0],
                                         // payload_byte[7:0], zero fill[1:0]
  output logic                m_tuser,   // kind
  output logic                m_tlast    // last_of_frame
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             step;
  logic             res_valid;
  wfd_result_t      res;
  logic             out_valid;
  wfd_result_t      out_res;

  assign step = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  wfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last_of_frame;
  assign m_tdata = {2'b00, out_res.payload_byte, out_res.frame_length,
                    out_res.was_masked, out_res.frame_opcode, out_res.frame_final};

`ifndef NO_ASSERTIONS
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_HEADER) |-> (m_tlast == (out_res.frame_length == '0)))
    else $error("header report last flag disagrees with frame length");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!in_valid || !m_tvalid || m_tready))
    else $error("input taken while a pending byte cannot advance");

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step) |=> (in_valid && $stable(in_byte)))
    else $error("stalled input byte was lost or changed");
`endif

endmodule
